### hw/rtl/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

  localparam int TICK_W      = 16;
  localparam int SEL_W       = 6;
  localparam int SPEED_W     = 16;
  localparam int CMD_W       = 2;
  localparam int FRAME_W     = 7;
  localparam int OUT_FRAME_W = 6;
  localparam int PERIOD_W    = 32;
  localparam int COUNT_W     = 7;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SPEED_W-1:0]  SPEED_ONE    = 16'd256;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd65536;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_SPEED   = 2'd1,
    CMD_JUMP    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP    = 2'd0,
    MODE_WRAP    = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_COUNT  = 2'd1,
    REG_MODE   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t                kind;
    logic [TICK_W-1:0]   tick_time;
    logic [SEL_W-1:0]    frame_sel;
    logic [SPEED_W-1:0]  speed_value;
  } item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] frame_period;
    logic [COUNT_W-1:0]  frame_count;
    mode_t               loop_mode;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/sfs_front.sv
`default_nettype none

module sfs_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [sfs_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic [sfs_pkg::CMD_W-1:0]         s_tuser,
  output logic                                   q_valid,
  output sfs_pkg::item_t                         q_item,
  input  wire logic                              q_pop
);

  sfs_pkg::item_t entries [2];
  sfs_pkg::item_t in_item;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    in_item.kind        = sfs_pkg::cmd_t'(s_tuser);
    in_item.tick_time   = s_tdata[15:0];
    in_item.frame_sel   = s_tdata[21:16];
    in_item.speed_value = s_tdata[37:22];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sfs_back.sv
`default_nettype none

module sfs_back #(
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sfs_pkg::cfg_t                     cfg,
  input  wire logic                              q_valid,
  input  wire sfs_pkg::item_t                    q_item,
  output logic                                   q_pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [sfs_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [sfs_pkg::FRAME_W-1:0]  frame, frame_next;
  logic [sfs_pkg::PERIOD_W-1:0] accum, accum_next;
  logic                         play, play_next;
  logic                         dir, dir_next;
  logic                         changed;

  logic [sfs_pkg::SPEED_W-1:0]  speed_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]        speed_vld;
  logic [sfs_pkg::SPEED_W-1:0]  mem_q;
  logic                         vld_q;
  logic                         byp;
  logic [sfs_pkg::SPEED_W-1:0]  byp_data;
  logic [sfs_pkg::SPEED_W-1:0]  speed;
  logic [AW-1:0]                raddr, waddr;
  logic                         we;

  logic [sfs_pkg::FRAME_W-1:0]  eff, last, f, tgt;
  logic                         set;
  logic [31:0]                  prod;
  logic [32:0]                  sum;
  logic [sfs_pkg::PERIOD_W-1:0] sat, acc_after;
  logic                         stepped;

  assign q_pop = q_valid && (!m_tvalid || m_tready);
  assign speed = byp ? byp_data : (vld_q ? mem_q : sfs_pkg::SPEED_ONE);
  assign raddr = AW'(frame_next);
  assign waddr = AW'(q_item.frame_sel);

  always_comb begin
    if (cfg.frame_count == '0) begin
      eff = 7'd1;
    end else if (int'(cfg.frame_count) > MAX_FRAMES) begin
      eff = sfs_pkg::FRAME_W'(MAX_FRAMES);
    end else begin
      eff = cfg.frame_count;
    end
    last = eff - 7'd1;
    f    = (frame < eff) ? frame : last;

    prod      = q_item.tick_time * speed;
    sum       = {1'b0, accum} + 33'(prod[31:8]);
    sat       = sum[32] ? '1 : sum[31:0];
    stepped   = sat > cfg.frame_period;
    acc_after = stepped ? sat - cfg.frame_period : sat;

    frame_next = frame;
    accum_next = accum;
    play_next  = play;
    dir_next   = dir;
    changed    = 1'b0;
    tgt        = frame;
    set        = 1'b0;
    we         = 1'b0;

    if (q_pop) begin
      unique case (q_item.kind)
        sfs_pkg::CMD_TICK: begin
          if (play) begin
            accum_next = acc_after;
            if (stepped) begin
              priority if (dir && ((f + 7'd1) < eff)) begin
                tgt = f + 7'd1;
                set = 1'b1;
              end else if (!dir && (f != '0)) begin
                tgt = f - 7'd1;
                set = 1'b1;
              end else if (cfg.loop_mode == sfs_pkg::MODE_WRAP) begin
                tgt = dir ? '0 : last;
                set = 1'b1;
              end else if (cfg.loop_mode == sfs_pkg::MODE_REVERSE) begin
                dir_next = !dir;
                set      = 1'b1;
                if (eff < 7'd2) begin
                  tgt = '0;
                end else begin
                  tgt = dir ? f - 7'd1 : f + 7'd1;
                end
              end else begin
                play_next = 1'b0;
              end
            end
          end
        end
        sfs_pkg::CMD_SPEED: begin
          we = int'(q_item.frame_sel) < MAX_FRAMES;
        end
        sfs_pkg::CMD_JUMP: begin
          tgt = ({1'b0, q_item.frame_sel} < eff) ? {1'b0, q_item.frame_sel} : last;
          set = 1'b1;
        end
        sfs_pkg::CMD_RESTART: begin
          frame_next = '0;
          accum_next = '0;
          changed    = 1'b1;
          play_next  = 1'b1;
          dir_next   = 1'b1;
        end
        default: begin
          frame_next = frame;
        end
      endcase
      if (set && (tgt != frame)) begin
        frame_next = tgt;
        changed    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      speed_mem[waddr] <= q_item.speed_value;
    end
    mem_q    <= speed_mem[raddr];
    byp_data <= q_item.speed_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_vld <= '0;
      vld_q     <= 1'b0;
      byp       <= 1'b0;
      frame     <= '0;
      accum     <= '0;
      play      <= 1'b1;
      dir       <= 1'b1;
      m_tvalid  <= 1'b0;
    end else begin
      if (we) begin
        speed_vld[waddr] <= 1'b1;
      end
      vld_q <= speed_vld[raddr];
      byp   <= we && (waddr == raddr);
      frame <= frame_next;
      accum <= accum_next;
      play  <= play_next;
      dir   <= dir_next;
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {7'b0, dir_next, play_next, changed,
                  frame_next[sfs_pkg::OUT_FRAME_W-1:0]};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sprite_frame_sequencer_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: tick_time, frame_sel, speed_value
// m_*       out  m_tvalid/m_tready  m_tdata: frame_now, changed, running, going_forward
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (cfg_ready always high)
//
// One request per cycle sustained while m_tready is high; an accepted request passes
// through the queue into the result register. The loop that sets the rate is the tick
// path in the back unit: speed read, 16x16 multiply, saturating add and period compare.
// Reset is synchronous; speed entries read as 1.0 until written (per-entry valid bits).
// A two-entry queue sits between intake and execution; the result register
// holds under m_tready low, and intake stalls only when the queue is full.
`default_nettype none

module sprite_frame_sequencer_top #(
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [15:0] tick_time, [21:16] frame_sel, [37:22] speed_value, [39:38] zero
  input  wire logic [sfs_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [1:0] cmd
  input  wire logic [sfs_pkg::CMD_W-1:0]         s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [5:0] frame_now, [6] changed, [7] running, [8] going_forward, [15:9] zero
  output logic [sfs_pkg::OUT_TDATA_W-1:0]        m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sfs_pkg::cfg_t  cfg;
  sfs_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_period <= sfs_pkg::PERIOD_RESET;
      cfg.frame_count  <= sfs_pkg::COUNT_RESET;
      cfg.loop_mode    <= sfs_pkg::MODE_WRAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sfs_pkg::reg_idx_t'(cfg_index))
        sfs_pkg::REG_PERIOD: cfg.frame_period <= cfg_data;
        sfs_pkg::REG_COUNT:  cfg.frame_count  <= cfg_data[sfs_pkg::COUNT_W-1:0];
        sfs_pkg::REG_MODE:   cfg.loop_mode    <= sfs_pkg::mode_t'(cfg_data[sfs_pkg::MODE_W-1:0]);
        default:             cfg              <= cfg;
      endcase
    end
  end

  sfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sfs_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_valid)
    else $error("accepted request not queued");

  a_full_has_work: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("intake stalled with empty queue");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !q_pop) |=> !m_tvalid)
    else $error("result repeated after handoff");

endmodule

`default_nettype wire
